// ----- rtl/contiguous_page_size_finder_defines.svh -----
// Assertion macros shared by the page size finder RTL.
`ifndef CONTIGUOUS_PAGE_SIZE_FINDER_DEFINES_SVH
`define CONTIGUOUS_PAGE_SIZE_FINDER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CPSF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CPSF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cpsf_pkg.sv -----
// Shared types, constants and helper functions of the page size finder.
`default_nettype none

package cpsf_pkg;

   // Field widths fixed by the interface
   localparam int ADDR_W      = 64;
   localparam int SEG_LEN_W   = 32;
   localparam int CSR_W       = 6;
   localparam int TOTAL_W     = 32;
   localparam int OUT_SHIFT_W = 6;
   localparam int RUN_PAGES_W = 33;
   localparam int EXP_W       = 7;

   // Lowest-set-bit index of an all-zero word
   localparam logic [EXP_W-1:0] LOW_BIT_NONE = 7'd64;

   // Segment markers carried from the front end to the back end
   typedef struct packed {
      logic first;
      logic last;
   } cpsf_flags_type;

   // One result beat
   typedef struct packed {
      logic [TOTAL_W-1:0]     total_pages;
      logic [OUT_SHIFT_W-1:0] block_shift;
      logic [TOTAL_W-1:0]     block_count;
      logic [OUT_SHIFT_W-1:0] block_order;
   } cpsf_rsp_type;

   // Index of the lowest set bit; 64 for zero
   function automatic logic [EXP_W-1:0] low_bit(input logic [ADDR_W-1:0] v);
      logic [EXP_W-1:0] n;
      n = LOW_BIT_NONE;
      for (int i = ADDR_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            n = EXP_W'(i);
         end
      end
      return n;
   endfunction

   // ceil(log2(v)); zero for v of zero or one
   function automatic logic [OUT_SHIFT_W-1:0] ceil_log2(input logic [TOTAL_W-1:0] v);
      logic [TOTAL_W-1:0]     dec;
      logic [OUT_SHIFT_W-1:0] n;
      dec = v - TOTAL_W'(1);
      n   = '0;
      for (int i = 0; i < TOTAL_W; i++) begin
         if (dec[i]) begin
            n = OUT_SHIFT_W'(i + 1);
         end
      end
      if (v == '0) begin
         n = '0;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/contiguous_page_size_finder.sv -----
// Top level of the contiguous page size finder.
// Usage:
//   The req_ channel is a queue input: a segment beat (first, virt_addr, seg_addr,
//   seg_len, last) is taken at a rising edge with req_push high and req_full low.
//   The rsp_ channel is a queue output: the oldest result sits on the rsp_ ports
//   while rsp_empty is low and leaves at an edge with rsp_pop high.
//   The csr_ channel writes the page shift cap (zero means no cap); csr_ready is
//   always high. Write it only while no region is in flight.
//   One result appears per segment marked last; other segments give none.
//   Throughput: one segment per cycle unless a last segment waits for the result
//   slot, set by the run tracking loop in the back end (compare against run end,
//   low-bit encode, add). A last segment goes through the command queue, the run
//   update, the result slot and the output queue before rsp_empty drops.
//   When the receiver stalls, results collect in the output queue, then in the
//   result slot; a last segment then waits at the head of the command queue and
//   holds back the segments behind it, and req_full rises once that queue fills.
//   Reset (synchronous, active high) empties both queues, clears the run state
//   and sets the shift cap to zero (no cap).
`default_nettype none

module contiguous_page_size_finder
   import cpsf_pkg::*;
#(
   parameter int BASE_PAGE_SHIFT = 12,
   parameter int CMD_DEPTH       = 4,
   parameter int RSP_DEPTH       = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_W-1:0]       csr_shift_cap,
   // segment input
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic                   req_first,
   input  wire logic [ADDR_W-1:0]      req_virt_addr,
   input  wire logic [ADDR_W-1:0]      req_seg_addr,
   input  wire logic [SEG_LEN_W-1:0]   req_seg_len,
   input  wire logic                   req_last,
   // result output
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [TOTAL_W-1:0]          rsp_total_pages,
   output logic [OUT_SHIFT_W-1:0]      rsp_block_shift,
   output logic [TOTAL_W-1:0]          rsp_block_count,
   output logic [OUT_SHIFT_W-1:0]      rsp_block_order
);

   localparam int PFN_W = ADDR_W - BASE_PAGE_SHIFT;
   localparam int LEN_W = SEG_LEN_W - BASE_PAGE_SHIFT;
   localparam int CMD_W = $bits(cpsf_flags_type) + EXP_W + PFN_W + LEN_W;
   localparam int RSP_W = $bits(cpsf_rsp_type);

   // Front end to command queue
   logic             cmd_full;
   logic             cmd_push;
   cpsf_flags_type   wr_flags;
   logic [EXP_W-1:0] wr_exp;
   logic [PFN_W-1:0] wr_pfn;
   logic [LEN_W-1:0] wr_len;
   logic [CMD_W-1:0] cmd_wdata;

   // Command queue to back end
   logic             cmd_empty;
   logic             cmd_pop;
   logic [CMD_W-1:0] cmd_rdata;
   cpsf_flags_type   rd_flags;
   logic [EXP_W-1:0] rd_exp;
   logic [PFN_W-1:0] rd_pfn;
   logic [LEN_W-1:0] rd_len;

   // Back end to output queue
   logic             rsp_full;
   logic             rsp_push;
   cpsf_rsp_type     rsp_wdata;
   cpsf_rsp_type     rsp_rdata;

   cpsf_front #(
      .BASE_PAGE_SHIFT (BASE_PAGE_SHIFT)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_shift_cap      (csr_shift_cap),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_first          (req_first),
      .req_virt_addr      (req_virt_addr),
      .req_seg_addr       (req_seg_addr),
      .req_seg_len        (req_seg_len),
      .req_last           (req_last),
      .cmd_full           (cmd_full),
      .cmd_push           (cmd_push),
      .cmd_flags          (wr_flags),
      .cmd_exp            (wr_exp),
      .cmd_pfn            (wr_pfn),
      .cmd_len            (wr_len)
   );

   assign cmd_wdata = {wr_flags, wr_exp, wr_pfn, wr_len};

   cpsf_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wdata),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rdata),
      .empty   (cmd_empty)
   );

   assign {rd_flags, rd_exp, rd_pfn, rd_len} = cmd_rdata;

   cpsf_back #(
      .BASE_PAGE_SHIFT (BASE_PAGE_SHIFT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_flags (rd_flags),
      .cmd_exp   (rd_exp),
      .cmd_pfn   (rd_pfn),
      .cmd_len   (rd_len),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata)
   );

   cpsf_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wdata),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rdata),
      .empty   (rsp_empty)
   );

   // Result fields
   assign rsp_total_pages = rsp_rdata.total_pages;
   assign rsp_block_shift = rsp_rdata.block_shift;
   assign rsp_block_count = rsp_rdata.block_count;
   assign rsp_block_order = rsp_rdata.block_order;

endmodule

`default_nettype wire

// ----- rtl/cpsf_fifo.sv -----
// Small register-based queue with first-word fall-through read.
`default_nettype none

module cpsf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_en;
   logic             rd_en;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_en   = push && !full;
   assign rd_en   = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cpsf_front.sv -----
// Front end: takes segment beats, holds the page shift cap, decodes each segment.
`default_nettype none

module cpsf_front
   import cpsf_pkg::*;
#(
   parameter int BASE_PAGE_SHIFT = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration write
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [CSR_W-1:0]                  csr_shift_cap,
   // segment input
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic                              req_first,
   input  wire logic [ADDR_W-1:0]                 req_virt_addr,
   input  wire logic [ADDR_W-1:0]                 req_seg_addr,
   input  wire logic [SEG_LEN_W-1:0]              req_seg_len,
   input  wire logic                              req_last,
   // decoded command toward the queue
   input  wire logic                              cmd_full,
   output logic                                   cmd_push,
   output cpsf_flags_type                         cmd_flags,
   output logic [EXP_W-1:0]                       cmd_exp,
   output logic [ADDR_W-BASE_PAGE_SHIFT-1:0]      cmd_pfn,
   output logic [SEG_LEN_W-BASE_PAGE_SHIFT-1:0]   cmd_len
);

   localparam int PFN_W = ADDR_W - BASE_PAGE_SHIFT;

   logic [CSR_W-1:0] max_shift_ff;
   logic [EXP_W-1:0] vpn_low;
   logic [CSR_W-1:0] cap;
   logic             cap_on;

   // Page shift cap register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_shift_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         max_shift_ff <= csr_shift_cap;
      end
   end

   // Accept a beat whenever the command queue has room
   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full;

   // Starting exponent: lowest set bit of the virtual page number, capped
   assign vpn_low = low_bit(ADDR_W'(req_virt_addr[ADDR_W-1:BASE_PAGE_SHIFT]));
   assign cap     = (max_shift_ff > CSR_W'(BASE_PAGE_SHIFT)) ?
                    max_shift_ff - CSR_W'(BASE_PAGE_SHIFT) : '0;
   assign cap_on  = (max_shift_ff != '0) && (EXP_W'(cap) < vpn_low);
   assign cmd_exp = cap_on ? EXP_W'(cap) : vpn_low;

   // Page-granular fields of the segment
   assign cmd_flags.first = req_first;
   assign cmd_flags.last  = req_last;
   assign cmd_pfn         = PFN_W'(req_seg_addr[ADDR_W-1:BASE_PAGE_SHIFT]);
   assign cmd_len         = req_seg_len[SEG_LEN_W-1:BASE_PAGE_SHIFT];

endmodule

`default_nettype wire

// ----- rtl/cpsf_back.sv -----
// Back end: tracks contiguous runs and the alignment exponent, formats results.
`default_nettype none
`include "contiguous_page_size_finder_defines.svh"

module cpsf_back
   import cpsf_pkg::*;
#(
   parameter int BASE_PAGE_SHIFT = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // decoded command from the queue
   input  wire logic                              cmd_empty,
   output logic                                   cmd_pop,
   input  wire cpsf_flags_type                    cmd_flags,
   input  wire logic [EXP_W-1:0]                  cmd_exp,
   input  wire logic [ADDR_W-BASE_PAGE_SHIFT-1:0] cmd_pfn,
   input  wire logic [SEG_LEN_W-BASE_PAGE_SHIFT-1:0] cmd_len,
   // result toward the output queue
   input  wire logic                              rsp_full,
   output logic                                   rsp_push,
   output cpsf_rsp_type                           rsp_data
);

   localparam int PFN_W = ADDR_W - BASE_PAGE_SHIFT;
   localparam int END_W = PFN_W + 1;

   // Run state
   logic                   run_none_ff, run_none_in;
   logic [PFN_W-1:0]       run_base_ff, run_base_in;
   logic [END_W-1:0]       run_end_ff, run_end_in;
   logic [RUN_PAGES_W-1:0] run_pages_ff, run_pages_in;
   logic [EXP_W-1:0]       align_exp_ff, align_exp_in;
   logic [TOTAL_W-1:0]     page_total_ff, page_total_in;

   // Finished region waiting for formatting
   logic                   fin_valid_ff, fin_valid_in;
   logic [TOTAL_W-1:0]     fin_total_ff;
   logic [EXP_W-1:0]       fin_exp_ff;

   logic                   fin_free;
   logic                   none0;
   logic [RUN_PAGES_W-1:0] pages0;
   logic [TOTAL_W-1:0]     total0;
   logic [EXP_W-1:0]       exp0;
   logic                   new_run;
   logic [EXP_W-1:0]       gap_low;
   logic [RUN_PAGES_W-1:0] pages_start;
   logic [RUN_PAGES_W:0]   pages_sum;
   logic [TOTAL_W:0]       total_sum;

   logic [OUT_SHIFT_W-1:0] ord_bits;
   logic [OUT_SHIFT_W-1:0] blk_exp;
   logic [TOTAL_W:0]       round_mask;
   logic [TOTAL_W:0]       round_sum;

   // Take a command unless it closes a region and the result slot is busy
   assign fin_free = !fin_valid_ff || !rsp_full;
   assign cmd_pop  = !cmd_empty && (!cmd_flags.last || fin_free);
   assign rsp_push = fin_valid_ff && !rsp_full;

   // State as seen by this segment: a first segment starts from a clean region
   assign none0  = cmd_flags.first ? 1'b1 : run_none_ff;
   assign pages0 = cmd_flags.first ? '0 : run_pages_ff;
   assign total0 = cmd_flags.first ? '0 : page_total_ff;
   assign exp0   = cmd_flags.first ? cmd_exp : align_exp_ff;

   // Discontinuity: the segment does not start where the current run ends
   assign new_run = none0 || (END_W'(cmd_pfn) != run_end_ff);
   assign gap_low = low_bit(ADDR_W'(cmd_pfn) | ADDR_W'(pages0));

   // Saturating page counts
   assign pages_start = new_run ? '0 : pages0;
   assign pages_sum   = {1'b0, pages_start} + (RUN_PAGES_W + 1)'(cmd_len);
   assign total_sum   = {1'b0, total0} + (TOTAL_W + 1)'(cmd_len);

   always_comb begin
      run_none_in   = run_none_ff;
      run_base_in   = run_base_ff;
      run_end_in    = run_end_ff;
      run_pages_in  = run_pages_ff;
      align_exp_in  = align_exp_ff;
      page_total_in = page_total_ff;
      if (cmd_pop) begin
         run_none_in   = 1'b0;
         run_base_in   = new_run ? cmd_pfn : run_base_ff;
         run_pages_in  = pages_sum[RUN_PAGES_W] ? '1 : pages_sum[RUN_PAGES_W-1:0];
         run_end_in    = END_W'(run_base_in) + END_W'(run_pages_in);
         align_exp_in  = (new_run && (gap_low < exp0)) ? gap_low : exp0;
         page_total_in = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_none_ff   <= 1'b1;
         run_pages_ff  <= '0;
         align_exp_ff  <= '0;
         page_total_ff <= '0;
      end else begin
         run_none_ff   <= run_none_in;
         run_pages_ff  <= run_pages_in;
         align_exp_ff  <= align_exp_in;
         page_total_ff <= page_total_in;
      end
   end

   always_ff @(posedge clock) begin
      run_base_ff <= run_base_in;
      run_end_ff  <= run_end_in;
   end

   // Result slot: loaded by a last segment, drained into the output queue
   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (cmd_pop && cmd_flags.last) begin
         fin_valid_in = 1'b1;
      end else if (rsp_push) begin
         fin_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd_flags.last) begin
         fin_total_ff <= page_total_in;
         fin_exp_ff   <= align_exp_in;
      end
   end

   // Formatting: exponent limited to the size order, block count rounded up
   assign ord_bits   = ceil_log2(fin_total_ff);
   assign blk_exp    = (fin_exp_ff < EXP_W'(ord_bits)) ? OUT_SHIFT_W'(fin_exp_ff) : ord_bits;
   assign round_mask = ((TOTAL_W + 1)'(1) << blk_exp) - (TOTAL_W + 1)'(1);
   assign round_sum  = {1'b0, fin_total_ff} + round_mask;

   assign rsp_data.total_pages = fin_total_ff;
   assign rsp_data.block_shift = OUT_SHIFT_W'(BASE_PAGE_SHIFT) + blk_exp;
   assign rsp_data.block_count = TOTAL_W'(round_sum >> blk_exp);
   assign rsp_data.block_order = ord_bits - blk_exp;

   // Checks
   `CPSF_ASSERT_NXT(a_fin_hold, clock, reset, fin_valid_ff && rsp_full, fin_valid_ff && $stable(fin_total_ff) && $stable(fin_exp_ff), "pending result changed while output queue was full")
   `CPSF_ASSERT_IMP(a_fin_no_overrun, clock, reset, fin_valid_ff && rsp_full, !(cmd_pop && cmd_flags.last), "last segment taken while result slot was blocked")
   `CPSF_ASSERT_NXT(a_fin_load, clock, reset, cmd_pop && cmd_flags.last, fin_valid_ff, "last segment did not load the result slot")
   `CPSF_ASSERT_IMP(a_run_clean, clock, reset, run_none_ff, run_pages_ff == '0, "page count held without an open run")
   `CPSF_ASSERT_IMP(a_exp_range, clock, reset, 1'b1, align_exp_ff <= LOW_BIT_NONE, "alignment exponent out of range")

endmodule

`default_nettype wire
